[hdl/seconds_to_date_bcd_top_defines.svh]
// ----------------------------------------------------------------------------
// Seconds-to-date assertion macros
// Shared property macros for the seconds-to-date checker.
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_DATE_BCD_TOP_DEFINES_SVH
`define SECONDS_TO_DATE_BCD_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SDB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SDB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sdb_pkg.sv]
// ----------------------------------------------------------------------------
// Seconds-to-date package
// Constants, stage types and the two-digit BCD helper.
// ----------------------------------------------------------------------------
package sdb_pkg;

    // Reciprocals for exact division by constants (floor(x*M >> k))
    localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // x/675,  x < 2^25, k = 35
    localparam logic [16:0] CYC_RECIP   = 17'd91868;     // x/1461, x < 2^16, k = 27
    localparam logic [13:0] HOUR_RECIP  = 14'd9321;      // x/225,  x < 2^13, k = 21
    localparam logic [10:0] MIN_RECIP   = 11'd1093;      // x/15,   x < 2^10, k = 14
    localparam logic [7:0]  TENS_RECIP  = 8'd205;        // x/10,   x < 2^8,  k = 11

    // Calendar constants
    localparam logic [16:0] DAY_SECS    = 17'd86400;
    localparam logic [16:0] HOUR_SECS   = 17'd3600;
    localparam logic [11:0] MIN_SECS    = 12'd60;
    localparam logic [10:0] CYC_DAYS    = 11'd1461;
    localparam logic [10:0] LEAP_DAYS   = 11'd366;
    localparam logic [10:0] YEAR_DAYS   = 11'd365;

    // Day count and time of day after the first split
    typedef struct packed {
        logic [15:0] days;
        logic [5:0]  cyc;
        logic [16:0] sod;
    } t_split;

    // Date result
    typedef struct packed {
        logic [7:0] year;
        logic [8:0] day;
        logic       leap;
        logic [7:0] year_bcd;
        logic [9:0] day_bcd;
    } t_date;

    // Time-of-day result
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [5:0] hour_bcd;
        logic [6:0] minute_bcd;
    } t_tod;

    // Value below 100 to {tens, units} BCD
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] units;
        tens = '0;
        for (int i = 1; i < 10; i++) begin
            if (v >= 7'(i * 10)) begin
                tens = 4'(i);
            end
        end
        units = v - 7'({3'b000, tens} * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

[hdl/sdb_split.sv]
// ----------------------------------------------------------------------------
// Seconds-to-date day split
// Splits the seconds count into whole days, four-year cycles and
// seconds of day. Two register stages.
// ----------------------------------------------------------------------------
module sdb_split import sdb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_seconds,
    output logic        o_valid,
    output t_split      o_split
);

    logic        r_v1;
    logic        r_v2;
    logic [31:0] r_s1;
    logic [50:0] r_p1;
    logic [50:0] n_p1;
    t_split      r_split;
    t_split      n_split;
    logic [15:0] days;
    logic [32:0] dsec;
    logic [32:0] cprod;

    // Stage 1: seconds/128 times reciprocal of 675
    assign n_p1 = 51'(i_seconds[31:7]) * 51'(DAY_RECIP);

    // Stage 2: day count, cycle count, seconds of day
    always_comb begin
        days          = r_p1[50:35];
        dsec          = 33'(days) * 33'(DAY_SECS);
        cprod         = 33'(days) * 33'(CYC_RECIP);
        n_split.days  = days;
        n_split.cyc   = cprod[32:27];
        n_split.sod   = r_s1[16:0] - dsec[16:0];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_s1    <= i_seconds;
        r_p1    <= n_p1;
        r_split <= n_split;
    end

    assign o_valid = r_v2;
    assign o_split = r_split;

endmodule

[hdl/sdb_date.sv]
// ----------------------------------------------------------------------------
// Seconds-to-date calendar stages
// Day count to year, day of year, leap flag and their BCD digits.
// Four register stages.
// ----------------------------------------------------------------------------
module sdb_date import sdb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_split i_split,
    output logic   o_valid,
    output t_date  o_date
);

    localparam logic [10:0] YEAR2_START = 11'd730;
    localparam logic [10:0] YEAR3_START = 11'd1095;
    localparam logic [8:0]  HUNDRED     = 9'd100;

    logic        r_va, r_vb, r_vc, r_vd;
    // stage A
    logic [10:0] r_dcyc;
    logic [5:0]  r_cyc;
    logic [16:0] cmul;
    logic [10:0] n_dcyc;
    // stage B
    logic [7:0]  r_year_b;
    logic [8:0]  r_day_b;
    logic        r_leap_b;
    logic [7:0]  n_year_b;
    logic [8:0]  n_day_b;
    logic        n_leap_b;
    logic [10:0] t;
    logic [1:0]  yin;
    logic [10:0] base;
    // stage C
    logic [15:0] r_ytp;
    logic [7:0]  r_year_c;
    logic [8:0]  r_day_c;
    logic        r_leap_c;
    logic [1:0]  r_dh;
    logic [6:0]  r_d2;
    logic [15:0] n_ytp;
    logic [1:0]  n_dh;
    logic [6:0]  n_d2;
    // stage D
    t_date       r_date;
    t_date       n_date;
    logic [4:0]  yt;
    logic [7:0]  yu;

    // Stage A: day within the four-year cycle
    always_comb begin
        cmul   = 17'(i_split.cyc) * 17'(CYC_DAYS);
        n_dcyc = 11'(17'(i_split.days) - cmul);
    end

    // Stage B: year within cycle, day of year
    always_comb begin
        n_leap_b = (r_dcyc < LEAP_DAYS);
        t        = r_dcyc - 11'd1;
        priority if (t >= YEAR3_START) begin
            yin  = 2'd3;
            base = YEAR3_START;
        end else if (t >= YEAR2_START) begin
            yin  = 2'd2;
            base = YEAR2_START;
        end else begin
            yin  = 2'd1;
            base = YEAR_DAYS;
        end
        if (n_leap_b) begin
            n_year_b = {r_cyc, 2'b00};
            n_day_b  = 9'(r_dcyc) + 9'd1;
        end else begin
            n_year_b = {r_cyc, yin};
            n_day_b  = 9'(t - base) + 9'd1;
        end
    end

    // Stage C: year tens product, day hundreds
    always_comb begin
        n_ytp = 16'(r_year_b) * 16'(TENS_RECIP);
        priority if (r_day_b >= 9'd300) begin
            n_dh = 2'd3;
        end else if (r_day_b >= 9'd200) begin
            n_dh = 2'd2;
        end else if (r_day_b >= HUNDRED) begin
            n_dh = 2'd1;
        end else begin
            n_dh = 2'd0;
        end
        n_d2 = 7'(r_day_b - 9'({7'd0, n_dh} * HUNDRED));
    end

    // Stage D: BCD packing
    always_comb begin
        yt              = r_ytp[15:11];
        yu              = r_year_c - 8'({3'b000, yt} * 8'd10);
        n_date.year     = r_year_c;
        n_date.day      = r_day_c;
        n_date.leap     = r_leap_c;
        n_date.year_bcd = {yt[3:0], yu[3:0]};
        n_date.day_bcd  = {r_dh, bcd2(r_d2)};
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_dcyc   <= n_dcyc;
        r_cyc    <= i_split.cyc;
        r_year_b <= n_year_b;
        r_day_b  <= n_day_b;
        r_leap_b <= n_leap_b;
        r_ytp    <= n_ytp;
        r_year_c <= r_year_b;
        r_day_c  <= r_day_b;
        r_leap_c <= r_leap_b;
        r_dh     <= n_dh;
        r_d2     <= n_d2;
        r_date   <= n_date;
    end

    assign o_valid = r_vd;
    assign o_date  = r_date;

endmodule

[hdl/sdb_tod.sv]
// ----------------------------------------------------------------------------
// Seconds-to-date time-of-day stages
// Seconds of day to hour, minute, second and BCD digits.
// Four register stages.
// ----------------------------------------------------------------------------
module sdb_tod import sdb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_split i_split,
    output logic   o_valid,
    output t_tod   o_tod
);

    logic        r_va, r_vb, r_vc, r_vd;
    // stage A
    logic [26:0] r_hp;
    logic [16:0] r_sod;
    logic [26:0] n_hp;
    // stage B
    logic [4:0]  r_hour_b;
    logic [11:0] r_rmin_b;
    logic [4:0]  hour;
    logic [11:0] n_rmin;
    // stage C
    logic [20:0] r_mp;
    logic [11:0] r_rmin_c;
    logic [4:0]  r_hour_c;
    logic [5:0]  r_hour_bcd;
    logic [20:0] n_mp;
    logic [7:0]  hb;
    // stage D
    t_tod        r_tod;
    t_tod        n_tod;
    logic [5:0]  minute;
    logic [7:0]  mb;

    // Stage A: (sod/16) times reciprocal of 225
    assign n_hp = 27'(i_split.sod[16:4]) * 27'(HOUR_RECIP);

    // Stage B: hour and seconds within hour
    always_comb begin
        hour   = r_hp[25:21];
        n_rmin = 12'(r_sod - 17'(hour) * HOUR_SECS);
    end

    // Stage C: minute product, hour BCD
    always_comb begin
        n_mp = 21'(r_rmin_b[11:2]) * 21'(MIN_RECIP);
        hb   = bcd2(7'(r_hour_b));
    end

    // Stage D: minute, second, minute BCD
    always_comb begin
        minute           = r_mp[19:14];
        mb               = bcd2(7'(minute));
        n_tod.hour       = r_hour_c;
        n_tod.minute     = minute;
        n_tod.second     = 6'(r_rmin_c - 12'(minute) * MIN_SECS);
        n_tod.hour_bcd   = r_hour_bcd;
        n_tod.minute_bcd = {mb[6:4], mb[3:0]};
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_hp       <= n_hp;
        r_sod      <= i_split.sod;
        r_hour_b   <= hour;
        r_rmin_b   <= n_rmin;
        r_mp       <= n_mp;
        r_rmin_c   <= r_rmin_b;
        r_hour_c   <= r_hour_b;
        r_hour_bcd <= {hb[5:4], hb[3:0]};
        r_tod      <= n_tod;
    end

    assign o_valid = r_vd;
    assign o_tod   = r_tod;

endmodule

[hdl/seconds_to_date_bcd_top.sv]
// ----------------------------------------------------------------------------
// Seconds-to-date converter, top level
// Seconds since a leap-year epoch to year, day of year, time of day and
// radio time code BCD digits.
// ----------------------------------------------------------------------------
//  Channel   | Handshake              | Word
//  ----------+------------------------+-------------------------------------
//  command   | i_start, o_busy        | i_seconds
//  result    | o_valid (1-cycle)      | o_year .. o_minute_bcd
//
//  One word is taken per clock while o_busy is low; results follow after the
//  six register stages (two for the day split, four for the parallel date
//  and time-of-day paths, each stage at most one multiply deep).
//  o_busy is high during reset and clears once reset is sampled released.
//  Synchronous active-low reset clears the valid bits and raises busy.
//  Results leave in a single strobed cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module seconds_to_date_bcd_top import sdb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_seconds,
    output logic        o_valid,
    output logic [7:0]  o_year,
    output logic [8:0]  o_day_of_year,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic        o_leap_year,
    output logic [7:0]  o_year_bcd,
    output logic [9:0]  o_day_bcd,
    output logic [5:0]  o_hour_bcd,
    output logic [6:0]  o_minute_bcd
);

    logic   r_busy;
    logic   accept;
    logic   split_valid;
    t_split split;
    logic   date_valid;
    t_date  date;
    logic   tod_valid;
    t_tod   tod;

    // Busy only while coming out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign accept = i_start & ~r_busy;

    // Day split
    sdb_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_seconds (i_seconds),
        .o_valid   (split_valid),
        .o_split   (split)
    );

    // Calendar path
    sdb_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .i_split (split),
        .o_valid (date_valid),
        .o_date  (date)
    );

    // Time-of-day path
    sdb_tod u_tod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .i_split (split),
        .o_valid (tod_valid),
        .o_tod   (tod)
    );

    // Both paths are equally deep
    assign o_valid       = date_valid & tod_valid;
    assign o_year        = date.year;
    assign o_day_of_year = date.day;
    assign o_leap_year   = date.leap;
    assign o_year_bcd    = date.year_bcd;
    assign o_day_bcd     = date.day_bcd;
    assign o_hour        = tod.hour;
    assign o_minute      = tod.minute;
    assign o_second      = tod.second;
    assign o_hour_bcd    = tod.hour_bcd;
    assign o_minute_bcd  = tod.minute_bcd;

endmodule

[hdl/sdb_checker.sv]
// ----------------------------------------------------------------------------
// Seconds-to-date port checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "seconds_to_date_bcd_top_defines.svh"

module sdb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [31:0] i_seconds,
    input logic        o_valid,
    input logic [7:0]  o_year,
    input logic [8:0]  o_day_of_year,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second,
    input logic        o_leap_year,
    input logic [7:0]  o_year_bcd,
    input logic [9:0]  o_day_bcd,
    input logic [5:0]  o_hour_bcd,
    input logic [6:0]  o_minute_bcd
);

    logic taken;
    logic day_ok;
    logic tod_ok;
    logic leap_ok;

    // Helper terms
    assign taken   = i_start && !o_busy;
    assign day_ok  = (o_day_of_year >= 9'd1) && (o_day_of_year <= 9'd366);
    assign tod_ok  = (o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60)
                     && (o_hour_bcd[3:0] <= 4'd9) && (o_minute_bcd[3:0] <= 4'd9);
    assign leap_ok = (o_leap_year == (o_year[1:0] == 2'b00))
                     && (o_leap_year || (o_day_of_year <= 9'd365));

    // Every result traces back to a word taken earlier at the command port
    `SDB_ASSERT_NOW(a_latency, i_clk, i_rst_n, o_valid, $past(taken, 6), "result without command")

    // Day of year stays within a leap year's length
    `SDB_ASSERT_NOW(a_day_range, i_clk, i_rst_n, o_valid, day_ok, "day of year out of range")

    // Time of day in range and BCD units digits decimal
    `SDB_ASSERT_NOW(a_tod_range, i_clk, i_rst_n, o_valid, tod_ok, "time of day out of range")

    // Leap year is the first of each cycle; only it reaches day 366
    `SDB_ASSERT_NOW(a_leap, i_clk, i_rst_n, o_valid, leap_ok, "leap flag inconsistent")

    // Busy is low once reset has been sampled released
    `SDB_ASSERT_NOW(a_busy, i_clk, i_rst_n, $past(i_rst_n), !o_busy, "busy high outside reset")

endmodule

bind seconds_to_date_bcd_top sdb_checker u_sdb_checker (.*);

[bench/seconds_to_date_bcd_top_tb.sv]
// ----------------------------------------------------------------------------
// Seconds-to-date converter testbench
// Feeds second counts through the start/busy command port and checks every
// strobed result word against a calendar predictor kept in the bench.
// Corner counts (minute, hour, day, year and cycle edges, year 100 and the
// top of the 32-bit range) go first, then biased random counts.
// ----------------------------------------------------------------------------
module seconds_to_date_bcd_top_tb;

    // Calendar lengths in seconds
    localparam int unsigned CYCLE_LEN  = 126230400;  // one leap year plus three common
    localparam int unsigned LEAP_LEN   = 31622400;
    localparam int unsigned COMMON_LEN = 31536000;
    localparam int unsigned DAY_LEN    = 86400;
    localparam int unsigned HOUR_LEN   = 3600;
    localparam int unsigned MIN_LEN    = 60;

    localparam int unsigned RANDOM_WORDS = 1750;
    localparam int unsigned IDLE_PCT     = 14;
    localparam int unsigned QUIET_FROM   = 700;   // driver never idles in this window
    localparam int unsigned QUIET_TO     = 1000;
    localparam int unsigned DRAIN_CYCLES = 12;    // pipeline is six stages deep
    localparam int unsigned STALL_LIMIT  = 2000;

    // One converted date word
    typedef struct packed {
        logic [7:0] year;
        logic [8:0] day_of_year;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       leap_year;
        logic [7:0] year_bcd;
        logic [9:0] day_bcd;
        logic [5:0] hour_bcd;
        logic [6:0] minute_bcd;
    } t_date_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [31:0] i_seconds = '0;
    logic        o_busy;
    logic        o_valid;
    logic [7:0]  o_year;
    logic [8:0]  o_day_of_year;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic        o_leap_year;
    logic [7:0]  o_year_bcd;
    logic [9:0]  o_day_bcd;
    logic [5:0]  o_hour_bcd;
    logic [6:0]  o_minute_bcd;

    logic [31:0] seconds_backlog[$];
    t_date_word  dates_due[$];
    t_date_word  due_word;

    int unsigned words_sent = 0;
    int unsigned words_total = 0;
    int unsigned dates_seen = 0;
    int unsigned leap_dates = 0;
    int unsigned late_dates = 0;     // year 100 and above
    int unsigned error_count = 0;
    int unsigned stall_count = 0;

    seconds_to_date_bcd_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_seconds     (i_seconds),
        .o_valid       (o_valid),
        .o_year        (o_year),
        .o_day_of_year (o_day_of_year),
        .o_hour        (o_hour),
        .o_minute      (o_minute),
        .o_second      (o_second),
        .o_leap_year   (o_leap_year),
        .o_year_bcd    (o_year_bcd),
        .o_day_bcd     (o_day_bcd),
        .o_hour_bcd    (o_hour_bcd),
        .o_minute_bcd  (o_minute_bcd)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Calendar fields and time code digits for one second count
    function automatic t_date_word convert_seconds(input logic [31:0] secs);
        t_date_word  d;
        int unsigned cycles;
        int unsigned left;
        int unsigned yr;
        int unsigned dd;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        logic        leap;
        cycles = secs / CYCLE_LEN;
        left   = secs % CYCLE_LEN;
        if (left < LEAP_LEN) begin
            leap = 1'b1;
            yr   = 0;
        end else begin
            // drop the leap day, then split into common years
            leap = 1'b0;
            left = left - DAY_LEN;
            yr   = left / COMMON_LEN;
            left = left % COMMON_LEN;
        end
        yr   = yr + 4 * cycles;
        dd   = left / DAY_LEN + 1;
        left = left % DAY_LEN;
        hh   = left / HOUR_LEN;
        left = left % HOUR_LEN;
        mm   = left / MIN_LEN;
        ss   = left % MIN_LEN;
        d.year        = 8'(yr);
        d.day_of_year = 9'(dd);
        d.hour        = 5'(hh);
        d.minute      = 6'(mm);
        d.second      = 6'(ss);
        d.leap_year   = leap;
        // tens nibble wraps past year 159; keeps low bits of year/10
        d.year_bcd    = {4'(yr / 10), 4'(yr % 10)};
        d.day_bcd     = {2'(dd / 100), 4'((dd % 100) / 10), 4'(dd % 10)};
        d.hour_bcd    = {2'(hh / 10), 4'(hh % 10)};
        d.minute_bcd  = {3'(mm / 10), 4'(mm % 10)};
        return d;
    endfunction

    // Random count, biased toward day, year and cycle edges
    function automatic logic [31:0] pick_seconds();
        int unsigned pick;
        int unsigned base;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            return $urandom();
        end else if (pick < 60) begin
            // near a year edge inside a cycle (cycles 0..33 fit in 32 bits)
            base = $urandom_range(0, 33) * CYCLE_LEN + LEAP_LEN
                   + $urandom_range(0, 2) * COMMON_LEN;
            return base + $urandom_range(0, 200) - 100;
        end else if (pick < 80) begin
            // near a midnight
            base = ($urandom_range(1, 49700) * DAY_LEN);
            return base + $urandom_range(0, 120) - 60;
        end else if (pick < 90) begin
            base = $urandom_range(1, 33) * CYCLE_LEN;
            return base + $urandom_range(0, 200) - 100;
        end else begin
            // year 100 and above
            return $urandom_range(32'd3155760000, 32'hFFFF_FFFF);
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("date %0d %s got %0d want %0d",
                                      dates_seen, name, got, want));
        end
    endtask

    // Driver: present the next word, hold it while busy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                dates_due.push_back(convert_seconds(i_seconds));
                words_sent++;
            end
            if (!(i_start && o_busy)) begin
                if (seconds_backlog.size() > 0 &&
                    ((words_sent >= QUIET_FROM && words_sent < QUIET_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_seconds <= seconds_backlog.pop_front();
                    i_start   <= 1'b1;
                end else begin
                    i_start   <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (dates_due.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                due_word = dates_due.pop_front();
                dates_seen++;
                if (due_word.leap_year) leap_dates++;
                if (due_word.year >= 8'd100) late_dates++;
                check_field("year",        32'(o_year),        32'(due_word.year));
                check_field("day_of_year", 32'(o_day_of_year), 32'(due_word.day_of_year));
                check_field("hour",        32'(o_hour),        32'(due_word.hour));
                check_field("minute",      32'(o_minute),      32'(due_word.minute));
                check_field("second",      32'(o_second),      32'(due_word.second));
                check_field("leap_year",   32'(o_leap_year),   32'(due_word.leap_year));
                check_field("year_bcd",    32'(o_year_bcd),    32'(due_word.year_bcd));
                check_field("day_bcd",     32'(o_day_bcd),     32'(due_word.day_bcd));
                check_field("hour_bcd",    32'(o_hour_bcd),    32'(due_word.hour_bcd));
                check_field("minute_bcd",  32'(o_minute_bcd),  32'(due_word.minute_bcd));
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid) begin
                stall_count <= 0;
            end else if (stall_count + 1 >= STALL_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        // minute, hour and day edges in the first leap year
        seconds_backlog.push_back(32'd0);
        seconds_backlog.push_back(32'd59);
        seconds_backlog.push_back(32'd60);
        seconds_backlog.push_back(32'd3599);
        seconds_backlog.push_back(32'd3600);
        seconds_backlog.push_back(32'd86399);
        seconds_backlog.push_back(32'd86400);
        seconds_backlog.push_back(32'd8553600);      // day 100
        seconds_backlog.push_back(32'd31535999);     // end of day 365
        seconds_backlog.push_back(32'd31536000);     // leap day 366
        seconds_backlog.push_back(32'd31622399);     // last second of leap year
        // common years: leap day removed before the split
        seconds_backlog.push_back(32'd31622400);
        seconds_backlog.push_back(32'd63158399);
        seconds_backlog.push_back(32'd63158400);
        seconds_backlog.push_back(32'd94694400);
        seconds_backlog.push_back(32'd126230399);    // end of first cycle
        seconds_backlog.push_back(32'd126230400);
        // year tens above nine
        seconds_backlog.push_back(32'd3155759999);   // year 99
        seconds_backlog.push_back(32'd3155760000);   // year 100
        seconds_backlog.push_back(32'hAAAA_AAAA);
        seconds_backlog.push_back(32'h5555_5555);
        seconds_backlog.push_back(32'hFFFF_FFFF);    // year 136
        repeat (RANDOM_WORDS) seconds_backlog.push_back(pick_seconds());
        words_total = seconds_backlog.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent < words_total || dates_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d second counts: %0d in leap years, %0d in year 100 or later.",
                 dates_seen, leap_dates, late_dates);
        $display("%0d field mismatches.", error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
